// File: design/multi_pass_sphere_frustum_cull_defines.svh
// Assertion macros for the sphere frustum cull block.
`ifndef MULTI_PASS_SPHERE_FRUSTUM_CULL_DEFINES_SVH
`define MULTI_PASS_SPHERE_FRUSTUM_CULL_DEFINES_SVH
`ifndef SYNTHESIS
`define MPSFC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define MPSFC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define MPSFC_ASSERT_IMP(label, clk, rst_n, a, c)
`define MPSFC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: design/mpsfc_pkg.sv
`timescale 1ns / 1ps
package mpsfc_pkg;
  localparam int PLANES = 6;
  localparam int COEFFS = 4;
  localparam int VAL_W = 32;
  // Full-width plane sum: three Q32.32 products, two shifted terms.
  localparam int SUM_W = 68;
  localparam logic ACT_TEST = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam logic REG_VIEW_COUNT = 1'b0;
  localparam logic REG_CULL_ENABLE = 1'b1;
  typedef logic signed [VAL_W-1:0] coeff_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef struct packed {
    logic   vld;
    logic   last;
  } ctl_t;
endpackage

// File: design/mpsfc_ram.sv
`timescale 1ns / 1ps
module mpsfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/mpsfc_plane_eval.sv
`timescale 1ns / 1ps
// Evaluates one plane over two register stages: products, then the sum.
// The verdict is the sign bit of the registered sum.
module mpsfc_plane_eval (
  input  logic                  clk,
  input  logic [4*32-1:0]       plane,
  input  logic signed [31:0]    cx,
  input  logic signed [31:0]    cy,
  input  logic signed [31:0]    cz,
  input  logic [30:0]           rad,
  output logic                  cull_r
);
  logic signed [63:0] px_r, py_r, pz_r;
  logic signed [mpsfc_pkg::SUM_W-1:0] dr_r;
  mpsfc_pkg::sum_t sum_r, sum_nxt;
  logic signed [31:0] nx, ny, nz, dd;
  assign nx = plane[31:0];
  assign ny = plane[63:32];
  assign nz = plane[95:64];
  assign dd = plane[127:96];
  always_ff @(posedge clk) begin
    px_r <= nx * cx;
    py_r <= ny * cy;
    pz_r <= nz * cz;
    dr_r <= ({{(mpsfc_pkg::SUM_W-32){dd[31]}}, dd} <<< 16)
          + {{(mpsfc_pkg::SUM_W-47){1'b0}}, rad, 16'h0};
  end
  assign sum_nxt = mpsfc_pkg::SUM_W'(px_r) + mpsfc_pkg::SUM_W'(py_r)
                 + mpsfc_pkg::SUM_W'(pz_r) + dr_r;
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
  end
  assign cull_r = sum_r[mpsfc_pkg::SUM_W-1];
endmodule

// File: design/multi_pass_sphere_frustum_cull.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_ready  | action, slots, coeff, sphere
// out_     | output    | out_valid/out_ready| pass_mask, culled
// cfg_     | input     | APB psel/penable   | view_count, cull_enable
// A coefficient write is a read-modify-write of one plane row and holds the input during write-back.
// A sphere test reads one pass per cycle (one row of six planes, 768 bits) and offers its
// result once every pass has gone through memory read, two evaluation stages and collect.
// The input is refused while the test runs; busy clears as the result is handed on.
// rst_n is synchronous and active low; the plane memory is not cleared.
// One result may wait behind an unaccepted one; while it waits, the input stalls.
`include "multi_pass_sphere_frustum_cull_defines.svh"
module multi_pass_sphere_frustum_cull #(
  parameter int MAX_PASSES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [2:0]            in_pass_slot,
  input  logic [2:0]            in_plane_slot,
  input  logic [1:0]            in_coeff_slot,
  input  logic signed [31:0]    in_coeff_value,
  input  logic signed [31:0]    in_center_x,
  input  logic signed [31:0]    in_center_y,
  input  logic signed [31:0]    in_center_z,
  input  logic [30:0]           in_sphere_radius,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_pass_mask,
  output logic                  out_culled,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  localparam int PW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
  localparam int ROW_W = mpsfc_pkg::PLANES * mpsfc_pkg::COEFFS * 32;
  localparam int CW = 4;

  // Configuration registers.
  logic [3:0] view_count_r;
  logic       cull_enable_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_count_r  <= 4'd1;
      cull_enable_r <= 1'b1;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == mpsfc_pkg::REG_VIEW_COUNT) begin
        view_count_r <= cfg_pwdata[3:0];
      end else begin
        cull_enable_r <= cfg_pwdata[0];
      end
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == mpsfc_pkg::REG_VIEW_COUNT) begin
      cfg_prdata[3:0] = view_count_r;
    end else begin
      cfg_prdata[0] = cull_enable_r;
    end
  end

  // Effective pass count, clamped to 1..MAX_PASSES.
  logic [3:0] count_eff;
  always_comb begin
    if (view_count_r == 4'd0) begin
      count_eff = 4'd1;
    end else if (view_count_r > 4'(MAX_PASSES)) begin
      count_eff = 4'(MAX_PASSES);
    end else begin
      count_eff = view_count_r;
    end
  end

  // Plane memory: one row per pass. A coefficient write is a read-modify-
  // write of the row: read in the accept cycle, merge and write back next.
  logic             busy_r;
  logic             wb_r;
  logic             pend_r;
  logic [PW-1:0]    wb_pass_r;
  logic [2:0]       wb_plane_r;
  logic [1:0]       wb_coeff_r;
  logic [31:0]      wb_val_r;
  logic [ROW_W-1:0] row_rd, row_wr;
  logic [PW-1:0]    raddr;
  logic [PW-1:0]    rd_pass_r;
  logic [CW-1:0]    issue_r;
  logic             in_acc, acc_wr, acc_test, wr_ok;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]      rad_r;

  // The output register and one waiting result part the two sides, so a
  // transaction is refused only while a test runs, a row is being written
  // back or a second result is already queued.
  assign in_ready = !busy_r && !wb_r && !pend_r;
  assign in_acc   = in_valid && in_ready;
  assign acc_wr   = in_acc && (in_action == mpsfc_pkg::ACT_WRITE);
  assign acc_test = in_acc && (in_action == mpsfc_pkg::ACT_TEST);
  assign wr_ok    = (in_plane_slot < 3'(mpsfc_pkg::PLANES))
                 && ({1'b0, in_pass_slot} < 4'(MAX_PASSES));

  assign raddr = acc_wr ? in_pass_slot[PW-1:0] : rd_pass_r;

  always_comb begin
    row_wr = row_rd;
    row_wr[(32'(wb_plane_r) * 4 + 32'(wb_coeff_r)) * 32 +: 32] = wb_val_r;
  end

  mpsfc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PASSES)) u_planes (
    .clk   (clk),
    .we    (wb_r),
    .waddr (wb_pass_r),
    .wdata (row_wr),
    .raddr (raddr),
    .rdata (row_rd)
  );

  // Test sequencer: issue one pass read per cycle; results return through tag_r/tag_vld_r.
  logic [CW-1:0] cnt_r;
  logic [3:0]    tag_r [4];
  logic [3:0]    tag_vld_r;
  logic [7:0]    mask_r;
  logic          en_r;
  logic          done;
  always_ff @(posedge clk) begin
    if (acc_wr) begin
      wb_pass_r  <= in_pass_slot[PW-1:0];
      wb_plane_r <= in_plane_slot;
      wb_coeff_r <= in_coeff_slot;
      wb_val_r   <= in_coeff_value;
    end
    if (acc_test) begin
      cx_r  <= in_center_x;
      cy_r  <= in_center_y;
      cz_r  <= in_center_z;
      rad_r <= in_sphere_radius;
      en_r  <= cull_enable_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      wb_r      <= 1'b0;
      issue_r   <= '0;
      rd_pass_r <= '0;
      cnt_r     <= '0;
      tag_vld_r <= '0;
    end else begin
      wb_r <= acc_wr && wr_ok;
      tag_vld_r <= {tag_vld_r[2:0], busy_r && (issue_r != 4'd0)};
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
      tag_r[3] <= tag_r[2];
      tag_r[0] <= 4'(rd_pass_r);
      if (acc_test) begin
        busy_r    <= 1'b1;
        issue_r   <= count_eff;
        rd_pass_r <= '0;
        cnt_r     <= count_eff;
      end else if (busy_r) begin
        if (issue_r != 4'd0) begin
          issue_r   <= issue_r - 4'd1;
          rd_pass_r <= rd_pass_r + PW'(1);
        end
        if (tag_vld_r[3]) begin
          cnt_r <= cnt_r - 4'd1;
        end
        if (done) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Six plane evaluators, fed from the registered row.
  logic [5:0] cull_v;
  genvar g;
  generate
    for (g = 0; g < mpsfc_pkg::PLANES; g++) begin : g_pl
      mpsfc_plane_eval u_eval (
        .clk    (clk),
        .plane  (row_rd[g*128 +: 128]),
        .cx     (cx_r),
        .cy     (cy_r),
        .cz     (cz_r),
        .rad    (rad_r),
        .cull_r (cull_v[g])
      );
    end
  endgenerate

  // tag_vld_r[0] marks row data at the memory output; eval adds two stages,
  // so a pass verdict stands when tag_vld_r[2] is set; vsee_r and vtag_r collect it.
  logic [3:0] vtag_r;
  logic       vvld_r;
  logic       vsee_r;
  always_ff @(posedge clk) begin
    vtag_r <= tag_r[2];
    vsee_r <= (cull_v == 6'd0);
    if (!rst_n) begin
      vvld_r <= 1'b0;
    end else begin
      vvld_r <= busy_r && tag_vld_r[2];
    end
  end
  assign done = tag_vld_r[3] && (cnt_r == 4'd1);

  logic [7:0] mask_nxt, all_mask;
  assign all_mask = 8'((9'd1 << count_eff) - 9'd1);
  always_comb begin
    mask_nxt = mask_r;
    if (vvld_r) begin
      mask_nxt[vtag_r[2:0]] = vsee_r;
    end
  end

  // A finished result goes straight to the output register when it is free
  // or being emptied, and otherwise waits in the pending register.
  logic [7:0] pend_mask_r;
  logic       pend_culled_r;
  logic [7:0] res_mask;
  logic       res_culled;
  logic       res_fire;
  assign res_mask   = en_r ? mask_nxt : all_mask;
  assign res_culled = en_r ? (mask_nxt == 8'd0) : 1'b0;
  assign res_fire   = busy_r && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      mask_r    <= '0;
      pend_r    <= 1'b0;
    end else begin
      if (acc_test) begin
        mask_r <= '0;
      end else begin
        mask_r <= mask_nxt;
      end
      if (out_valid && out_ready) begin
        if (pend_r) begin
          out_pass_mask <= pend_mask_r;
          out_culled    <= pend_culled_r;
          pend_r        <= 1'b0;
        end else if (res_fire) begin
          out_pass_mask <= res_mask;
          out_culled    <= res_culled;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (res_fire) begin
        if (out_valid) begin
          pend_r        <= 1'b1;
          pend_mask_r   <= res_mask;
          pend_culled_r <= res_culled;
        end else begin
          out_valid     <= 1'b1;
          out_pass_mask <= res_mask;
          out_culled    <= res_culled;
        end
      end
    end
  end

  `MPSFC_ASSERT_IMP(a_no_acc_busy, clk, rst_n, busy_r, !in_ready)
  `MPSFC_ASSERT_IMP(a_culled_mask, clk, rst_n, out_valid, out_culled == (out_pass_mask == 8'd0))
  `MPSFC_ASSERT_NXT(a_wb_after_wr, clk, rst_n, acc_wr && wr_ok, wb_r)
  `MPSFC_ASSERT_IMP(a_pend_behind_out, clk, rst_n, pend_r, out_valid)
endmodule

// File: dv/multi_pass_sphere_frustum_cull_test.sv
`timescale 1ns / 1ps
module multi_pass_sphere_frustum_cull_test;

  localparam int STORE_WORDS = 192;
  localparam int MAX_PASS = 8;
  localparam int CYCLE_LIMIT = 2000000;
  // This margin covers both the wait for a result after its test is accepted and the
  // settling of a write.
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int NUM_PHASES = 8;
  localparam int NUM_DIRECTED = 17;
  localparam int UNKNOWN = -1;

  // Idling modes: which side of the block goes quiet, and how often.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic        action;
    logic [2:0]  pass_slot;
    logic [2:0]  plane_slot;
    logic [1:0]  coeff_slot;
    logic [31:0] coeff_value;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] radius;
    int          known_mask;
    int          known_culled;
  } cull_item_t;

  typedef struct {
    logic [7:0] pass_mask;
    logic       culled;
  } visibility_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [2:0]  in_pass_slot;
  logic [2:0]  in_plane_slot;
  logic [1:0]  in_coeff_slot;
  logic [31:0] in_coeff_value;
  logic [31:0] in_center_x;
  logic [31:0] in_center_y;
  logic [31:0] in_center_z;
  logic [30:0] in_sphere_radius;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_pass_mask;
  logic        out_culled;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  multi_pass_sphere_frustum_cull dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_pass_slot     (in_pass_slot),
    .in_plane_slot    (in_plane_slot),
    .in_coeff_slot    (in_coeff_slot),
    .in_coeff_value   (in_coeff_value),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_center_z      (in_center_z),
    .in_sphere_radius (in_sphere_radius),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pass_mask    (out_pass_mask),
    .out_culled       (out_culled),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // The predictor keeps its own copy of the plane memory and of both registers.
  logic signed [31:0] plane_mem [STORE_WORDS];
  logic [3:0]         view_count_q;
  logic               cull_enable_q;

  visibility_t pending_results[$];
  idle_mode_e  idle_mode;
  int          error_count = 0;
  int          cycle_count = 0;
  int          hold_requests;
  int          hold_served = 0;
  int          hold_left = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Whether one plane lets the sphere through. The sum is kept at 68 bits, as
  // wide as the block keeps it, so nothing wraps even at the extremes.
  function automatic logic plane_passes(int base, logic signed [31:0] cx,
                                        logic signed [31:0] cy,
                                        logic signed [31:0] cz,
                                        logic [30:0] radius);
    logic signed [67:0] acc;
    acc = 68'(longint'(plane_mem[base]) * longint'(cx));
    acc += 68'(longint'(plane_mem[base + 1]) * longint'(cy));
    acc += 68'(longint'(plane_mem[base + 2]) * longint'(cz));
    acc += 68'(longint'(plane_mem[base + 3]) * 64'sd65536);
    acc += 68'(longint'(radius) * 64'sd65536);
    return !acc[67];
  endfunction

  function automatic visibility_t predict_visibility(cull_item_t it);
    visibility_t res;
    int          passes;
    logic        seen;
    passes = (view_count_q == 0) ? 1 : (view_count_q > MAX_PASS) ? MAX_PASS : view_count_q;
    res.pass_mask = '0;
    for (int p = 0; p < passes; p++) begin
      seen = 1'b1;
      if (cull_enable_q) begin
        for (int pl = 0; pl < mpsfc_pkg::PLANES; pl++)
          if (!plane_passes((p * mpsfc_pkg::PLANES + pl) * mpsfc_pkg::COEFFS,
                            it.cx, it.cy, it.cz, it.radius))
            seen = 1'b0;
      end
      res.pass_mask[p] = seen;
    end
    res.culled = (res.pass_mask == 0);
    return res;
  endfunction

  // Offers one transaction, waiting the sender's gap first. Valid is left high
  // after acceptance so that back-to-back items need no lowering in between.
  task automatic offer_item(cull_item_t it);
    visibility_t res;
    int          idle_pct;
    idle_pct = (idle_mode == IDLE_SENDER) ? 60 : (idle_mode == IDLE_BOTH) ? 6 : 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid         = 1'b1;
    in_action        = it.action;
    in_pass_slot     = it.pass_slot;
    in_plane_slot    = it.plane_slot;
    in_coeff_slot    = it.coeff_slot;
    in_coeff_value   = it.coeff_value;
    in_center_x      = it.cx;
    in_center_y      = it.cy;
    in_center_z      = it.cz;
    in_sphere_radius = it.radius;
    forever begin
      @(posedge clk);
      if (in_ready)
        break;
    end
    if (it.action == mpsfc_pkg::ACT_WRITE) begin
      // Plane slots six and seven are outside the store and are dropped.
      if (it.plane_slot < mpsfc_pkg::PLANES)
        plane_mem[(it.pass_slot * mpsfc_pkg::PLANES + it.plane_slot) * mpsfc_pkg::COEFFS
                  + it.coeff_slot] = it.coeff_value;
    end else begin
      res = predict_visibility(it);
      if (it.known_mask != UNKNOWN) begin
        res.pass_mask = it.known_mask[7:0];
        res.culled    = it.known_culled[0];
      end
      pending_results.push_back(res);
    end
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic reg_sel, logic [31:0] value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {reg_sel, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready)
        break;
    end
    if (reg_sel == mpsfc_pkg::REG_VIEW_COUNT)
      view_count_q = value[3:0];
    else
      cull_enable_q = value[0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Mostly values within a few units so that planes cut through the spheres,
  // with the odd fully random word so that every bit is exercised.
  function automatic logic [31:0] random_q16();
    if ($urandom_range(7) == 0)
      return $urandom();
    return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
  endfunction

  function automatic cull_item_t random_item(int write_pct);
    cull_item_t it;
    it.action       = ($urandom_range(99) < write_pct) ? mpsfc_pkg::ACT_WRITE
                                                        : mpsfc_pkg::ACT_TEST;
    it.pass_slot    = 3'($urandom_range(7));
    it.plane_slot   = ($urandom_range(15) == 0) ? 3'($urandom_range(7))
                                                : 3'($urandom_range(5));
    it.coeff_slot   = 2'($urandom_range(3));
    it.coeff_value  = random_q16();
    it.cx           = random_q16();
    it.cy           = random_q16();
    it.cz           = random_q16();
    it.radius       = ($urandom_range(7) == 0) ? 31'($urandom())
                                               : 31'($urandom_range(0, 32'h20000));
    it.known_mask   = UNKNOWN;
    it.known_culled = UNKNOWN;
    return it;
  endfunction

  // Result channel: the receiver either stalls at random or, on request,
  // holds off for a long stretch so that the block backs up into its input.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready = 1'b0;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_ready = ($urandom_range(99) >= 60);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready = ($urandom_range(99) >= 6);
    end else begin
      out_ready = 1'b1;
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: pass_mask %0h culled %0b",
               out_pass_mask, out_culled);
        error_count++;
      end else begin
        visibility_t want;
        want = pending_results.pop_front();
        if (out_pass_mask !== want.pass_mask) begin
          $error("pass_mask expected %0h actual %0h", want.pass_mask, out_pass_mask);
          error_count++;
        end
        if (out_culled !== want.culled) begin
          $error("culled expected %0b actual %0b", want.culled, out_culled);
          error_count++;
        end
      end
    end
  end

  // Directed rows. The store has been zeroed beforehand, so every plane of
  // every pass is degenerate until a row changes it. A typed-in expectation
  // is used where the outcome is plain; UNKNOWN defers to the predictor.
  // Fields: action pass plane coeff value cx cy cz radius mask culled.
  cull_item_t directed_rows[NUM_DIRECTED] = '{
    // Degenerate planes never cull, even at the corners of the field ranges.
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'h80000000, 32'h80000000,
      32'h80000000, 31'h0, 1, 0},
    '{mpsfc_pkg::ACT_TEST, 3'd7, 3'd7, 2'd3, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
      32'h7FFFFFFF, 31'h7FFFFFFF, 1, 0},
    // Left plane of the camera pass becomes x >= -r.
    '{mpsfc_pkg::ACT_WRITE, 3'd0, 3'd0, 2'd0, 32'h00010000, 32'h0, 32'h0, 32'h0, 31'h0,
      UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'hFFFE0000, 32'h0, 32'h0,
      31'h10000, 0, 1},
    // Touching the plane exactly is not outside it.
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'hFFFF0000, 32'h0, 32'h0,
      31'h10000, 1, 0},
    // Plane slots six and seven are out of range and must be dropped.
    '{mpsfc_pkg::ACT_WRITE, 3'd0, 3'd6, 2'd0, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 31'h0,
      UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_WRITE, 3'd0, 3'd7, 2'd3, 32'h80000000, 32'h0, 32'h0, 32'h0, 31'h0,
      UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'hFFFE0000, 32'h0, 32'h0,
      31'h10000, 0, 1},
    // Most negative offset on the near plane outweighs the largest radius.
    '{mpsfc_pkg::ACT_WRITE, 3'd0, 3'd4, 2'd3, 32'h80000000, 32'h0, 32'h0, 32'h0, 31'h0,
      UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF,
      32'h7FFFFFFF, 31'h7FFFFFFF, 0, 1},
    '{mpsfc_pkg::ACT_WRITE, 3'd0, 3'd4, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0, 31'h0,
      UNKNOWN, UNKNOWN},
    // Extreme normals against extreme centres: the full-width sum matters here.
    '{mpsfc_pkg::ACT_WRITE, 3'd0, 3'd0, 2'd0, 32'h80000000, 32'h0, 32'h0, 32'h0, 31'h0,
      UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'h80000000, 32'h0, 32'h0, 31'h0,
      UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'h7FFFFFFF, 32'h0, 32'h0,
      31'h7FFFFFFF, UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_WRITE, 3'd0, 3'd1, 2'd2, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h0, 31'h0,
      UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'h80000000, 32'h7FFFFFFF,
      32'h80000000, 31'h0, UNKNOWN, UNKNOWN},
    '{mpsfc_pkg::ACT_TEST, 3'd0, 3'd0, 2'd0, 32'h0, 32'hFFF00000, 32'h0, 32'h00100000,
      31'h0, UNKNOWN, UNKNOWN}
  };

  // Register settings per phase, taking in zero and over-range pass counts
  // and culling switched off.
  int phase_view_count[NUM_PHASES] = '{8, 0, 15, 3, 8, 5, 1, 9};
  int phase_cull[NUM_PHASES]       = '{1, 1, 1, 0, 0, 1, 1, 1};

  initial begin
    cull_item_t it;
    hold_requests    = 0;
    idle_mode        = IDLE_NONE;
    view_count_q     = 4'd1;
    cull_enable_q    = 1'b1;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_action        = mpsfc_pkg::ACT_TEST;
    in_pass_slot     = '0;
    in_plane_slot    = '0;
    in_coeff_slot    = '0;
    in_coeff_value   = '0;
    in_center_x      = '0;
    in_center_y      = '0;
    in_center_z      = '0;
    in_sphere_radius = '0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // The plane memory comes out of reset undefined, so every coefficient is
    // written before any sphere is tested.
    for (int w = 0; w < STORE_WORDS; w++) begin
      it = random_item(100);
      it.pass_slot   = 3'(w / (mpsfc_pkg::PLANES * mpsfc_pkg::COEFFS));
      it.plane_slot  = 3'((w / mpsfc_pkg::COEFFS) % mpsfc_pkg::PLANES);
      it.coeff_slot  = 2'(w % mpsfc_pkg::COEFFS);
      it.coeff_value = '0;
      offer_item(it);
    end

    foreach (directed_rows[i])
      offer_item(directed_rows[i]);
    wait_until_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_register(mpsfc_pkg::REG_VIEW_COUNT, phase_view_count[ph]);
      write_register(mpsfc_pkg::REG_CULL_ENABLE, phase_cull[ph]);
      idle_mode = idle_mode_e'(ph % 4);
      // In one quiet phase the receiver holds off while tests keep coming,
      // so the block fills and must stall its input.
      if (ph == 4)
        hold_requests++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // In another, the sender stops half way until every result is back.
        if (ph == 5 && n == ITEMS_PER_PHASE / 2)
          wait_until_drained();
        offer_item(random_item((ph == 4 && n < 60) ? 10 : 45));
      end
      wait_until_drained();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
